[rtl/rslm_pkg.sv]
// ----------------------------------------------------------------------------
// rslm_pkg
// Shared types and constants for the RTP stream loss monitor.
// ----------------------------------------------------------------------------
`default_nettype none
package rslm_pkg;
    localparam int FLOW_SLOTS_DEF = 16;
    localparam logic [15:0] MIN_PORT_RST   = 16'd10000;
    localparam logic [15:0] BAND_FIRST_RST = 16'd5070;
    localparam logic [15:0] BAND_LAST_RST  = 16'd5074;
    localparam logic [7:0]  VERSION_RST    = 8'h80;

    localparam logic [1:0] REG_MIN_PORT   = 2'd0;
    localparam logic [1:0] REG_BAND_FIRST = 2'd1;
    localparam logic [1:0] REG_BAND_LAST  = 2'd2;
    localparam logic [1:0] REG_VERSION    = 2'd3;

    localparam logic CMD_PACKET = 1'b0;
    localparam logic CMD_TICK   = 1'b1;

    // contents of one flow entry
    typedef struct packed {
        logic        valid;
        logic [31:0] ip;
        logic [15:0] port;
        logic [15:0] seq_first;
        logic [15:0] seq_last;
        logic [15:0] rcvd;
        logic [15:0] rcvd_rep;
    } flow_t;

    // command broadcast to all cells
    typedef struct packed {
        logic        upd;
        logic [31:0] ip;
        logic [15:0] port;
        logic [15:0] seq;
    } pkt_t;
endpackage
`default_nettype wire

[rtl/rslm_cell.sv]
// ----------------------------------------------------------------------------
// rslm_cell
// One flow slot: key compare, packet update, and a shift stage for the report walk.
// ----------------------------------------------------------------------------
`default_nettype none
module rslm_cell (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire rslm_pkg::pkt_t  pkt,
    input  wire logic            claim,
    input  wire logic            shift,
    input  wire logic            wrap,
    input  wire rslm_pkg::flow_t prev,
    output rslm_pkg::flow_t      cur,
    output logic                 hit
);
    rslm_pkg::flow_t cell_reg, cell_next;

    assign cur = cell_reg;
    assign hit = cell_reg.valid && cell_reg.ip == pkt.ip && cell_reg.port == pkt.port;

    always_comb begin
        cell_next = cell_reg;
        if (shift) begin
            // report walk rotates entries; sync the report count as an entry leaves the head
            cell_next = prev;
            if (wrap && prev.valid)
                cell_next.rcvd_rep = prev.rcvd;
        end else if (pkt.upd && hit) begin
            if (pkt.seq == 16'd0) begin
                cell_next.seq_first = 16'd0;
                cell_next.seq_last  = 16'd0;
                cell_next.rcvd      = 16'd1;
                cell_next.rcvd_rep  = 16'd1;
            end else begin
                cell_next.seq_last = pkt.seq;
                cell_next.rcvd     = cell_reg.rcvd + 16'd1;
            end
        end else if (pkt.upd && claim) begin
            cell_next.valid     = 1'b1;
            cell_next.ip        = pkt.ip;
            cell_next.port      = pkt.port;
            cell_next.seq_first = pkt.seq;
            cell_next.seq_last  = pkt.seq;
            cell_next.rcvd      = 16'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cell_reg.valid    <= 1'b0;
            cell_reg.rcvd_rep <= 16'd0;
        end else begin
            cell_reg.valid    <= cell_next.valid;
            cell_reg.rcvd_rep <= cell_next.rcvd_rep;
        end
        cell_reg.ip        <= cell_next.ip;
        cell_reg.port      <= cell_next.port;
        cell_reg.seq_first <= cell_next.seq_first;
        cell_reg.seq_last  <= cell_next.seq_last;
        cell_reg.rcvd      <= cell_next.rcvd;
    end
endmodule
`default_nettype wire

[rtl/rtp_stream_loss_monitor_core.sv]
// ----------------------------------------------------------------------------
// rtp_stream_loss_monitor_core
// Per-flow RTP sequence loss tracker over a ring of flow cells.
// ----------------------------------------------------------------------------
// A packet item is registered on acceptance, then every cell compares its key
// in parallel and updates or is claimed round robin. A tick item rotates the
// ring of FLOW_SLOTS cells once, one slot per cycle unless the output stalls the
// walk, then the final pending report is flushed; each changed valid flow is
// captured from the head cell as it passes and held pending until the next
// changed flow or the walk end, which pushes it to the output.
// Results are held in an output register, so the walk stalls only when a
// result is not taken.
`default_nettype none
module rtp_stream_loss_monitor_core #(
    parameter int FLOW_SLOTS = rslm_pkg::FLOW_SLOTS_DEF
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_we,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [15:0] cfg_data,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic        s_command,
    input  wire logic [31:0] s_dest_ip,
    input  wire logic [15:0] s_dest_port,
    input  wire logic [7:0]  s_first_header_byte,
    input  wire logic [15:0] s_seq_number,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [3:0]       m_slot,
    output logic [31:0]      m_stream_ip,
    output logic [15:0]      m_stream_port,
    output logic [15:0]      m_first_seq,
    output logic [15:0]      m_last_seq,
    output logic [15:0]      m_packets_seen,
    output logic signed [17:0] m_packets_expected,
    output logic signed [17:0] m_packets_lost,
    output logic             m_last_report
);
    localparam int SW = $clog2(FLOW_SLOTS);
    localparam logic [SW-1:0] LAST_SLOT = SW'(FLOW_SLOTS - 1);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_PKT  = 2'd1;
    localparam logic [1:0] ST_WALK = 2'd2;

    logic [15:0] min_port_reg, band_first_reg, band_last_reg;
    logic [7:0]  version_reg;
    logic [1:0]  state_reg;
    logic [SW-1:0] next_slot_reg, walk_reg;
    logic          any_reg;
    rslm_pkg::pkt_t pkt_reg;

    rslm_pkg::flow_t cur [FLOW_SLOTS];
    logic [FLOW_SLOTS-1:0] hit;
    logic shift, any_hit, pass;

    // pending report held until the next changed flow or the walk end
    logic        pend_reg;
    logic [SW-1:0] pend_slot_reg;
    rslm_pkg::flow_t pend_reg_d;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            min_port_reg   <= rslm_pkg::MIN_PORT_RST;
            band_first_reg <= rslm_pkg::BAND_FIRST_RST;
            band_last_reg  <= rslm_pkg::BAND_LAST_RST;
            version_reg    <= rslm_pkg::VERSION_RST;
        end else if (cfg_we) begin
            unique case (cfg_index)
                rslm_pkg::REG_MIN_PORT:   min_port_reg   <= cfg_data;
                rslm_pkg::REG_BAND_FIRST: band_first_reg <= cfg_data;
                rslm_pkg::REG_BAND_LAST:  band_last_reg  <= cfg_data;
                rslm_pkg::REG_VERSION:    version_reg    <= cfg_data[7:0];
                default: ;
            endcase
        end
    end

    assign pass = (s_dest_port >= min_port_reg
                   || (s_dest_port >= band_first_reg && s_dest_port <= band_last_reg))
                  && s_first_header_byte == version_reg;
    assign any_hit = |hit;

    genvar g;
    generate
        for (g = 0; g < FLOW_SLOTS; g++) begin : g_cell
            rslm_pkg::pkt_t cpkt;
            assign cpkt.upd  = (state_reg == ST_PKT) && pkt_reg.upd;
            assign cpkt.ip   = pkt_reg.ip;
            assign cpkt.port = pkt_reg.port;
            assign cpkt.seq  = pkt_reg.seq;
            rslm_cell u_cell (
                .aclk(aclk), .aresetn(aresetn), .pkt(cpkt),
                .claim(!any_hit && next_slot_reg == SW'(g)),
                .shift(shift),
                .wrap(g == FLOW_SLOTS - 1),
                .prev(cur[(g + 1) % FLOW_SLOTS]),
                .cur(cur[g]), .hit(hit[g])
            );
        end
    endgenerate

    // head cell 0 holds slot walk_reg during the walk
    logic head_changed, out_free, out_load;
    assign head_changed = cur[0].valid && cur[0].rcvd != cur[0].rcvd_rep;
    assign out_free = !m_valid || m_ready;
    // advance unless a changed flow would overwrite an undelivered pending one
    assign shift = (state_reg == ST_WALK) && (!(head_changed && pend_reg) || out_free);
    // accept input only in idle, and hold it off while the final report of a tick is still pending
    assign s_ready = (state_reg == ST_IDLE) && !any_reg;
    assign out_load = (state_reg == ST_WALK && shift && head_changed && pend_reg)
                      || (state_reg == ST_IDLE && any_reg && pend_reg && out_free);

    logic signed [17:0] exp_w;
    assign exp_w = 18'({2'b00, pend_reg_d.seq_last}) - 18'({2'b00, pend_reg_d.seq_first})
                   + 18'sd1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            next_slot_reg <= '0;
            walk_reg      <= '0;
            pend_reg      <= 1'b0;
            m_valid       <= 1'b0;
            any_reg       <= 1'b0;
        end else begin
            if (out_load) m_valid <= 1'b1;
            else if (m_ready) m_valid <= 1'b0;
            unique case (state_reg)
                ST_IDLE: begin
                    if (s_valid && s_ready) begin
                        if (s_command == rslm_pkg::CMD_TICK) begin
                            state_reg <= ST_WALK;
                            walk_reg  <= '0;
                        end else begin
                            state_reg <= ST_PKT;
                        end
                    end
                end
                ST_PKT: begin
                    if (pkt_reg.upd && !any_hit)
                        next_slot_reg <= (next_slot_reg == LAST_SLOT) ? '0
                                                                      : next_slot_reg + 1'b1;
                    state_reg <= ST_IDLE;
                end
                ST_WALK: begin
                    if (shift) begin
                        if (head_changed) begin
                            if (pend_reg) begin
                                m_slot             <= 4'(pend_slot_reg);
                                m_stream_ip        <= pend_reg_d.ip;
                                m_stream_port      <= pend_reg_d.port;
                                m_first_seq        <= pend_reg_d.seq_first;
                                m_last_seq         <= pend_reg_d.seq_last;
                                m_packets_seen     <= pend_reg_d.rcvd;
                                m_packets_expected <= exp_w;
                                m_packets_lost     <= exp_w - 18'({2'b00, pend_reg_d.rcvd});
                                m_last_report      <= 1'b0;
                            end
                            pend_reg      <= 1'b1;
                            pend_reg_d    <= cur[0];
                            pend_slot_reg <= walk_reg;
                        end
                        walk_reg <= walk_reg + 1'b1;
                        if (walk_reg == LAST_SLOT) begin
                            state_reg <= ST_IDLE;
                            any_reg   <= 1'b1;
                        end
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
            // flush the final pending report; hold input off until done
            if (state_reg == ST_IDLE && any_reg) begin
                if (!pend_reg) begin
                    any_reg <= 1'b0;
                end else if (out_free) begin
                    m_slot             <= 4'(pend_slot_reg);
                    m_stream_ip        <= pend_reg_d.ip;
                    m_stream_port      <= pend_reg_d.port;
                    m_first_seq        <= pend_reg_d.seq_first;
                    m_last_seq         <= pend_reg_d.seq_last;
                    m_packets_seen     <= pend_reg_d.rcvd;
                    m_packets_expected <= exp_w;
                    m_packets_lost     <= exp_w - 18'({2'b00, pend_reg_d.rcvd});
                    m_last_report      <= 1'b1;
                    pend_reg           <= 1'b0;
                    any_reg            <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            pkt_reg.upd  <= pass;
            pkt_reg.ip   <= s_dest_ip;
            pkt_reg.port <= s_dest_port;
            pkt_reg.seq  <= s_seq_number;
        end
    end
endmodule
`default_nettype wire

[verif/rtp_stream_loss_monitor_core_tb.sv]
// ----------------------------------------------------------------------------
// rtp_stream_loss_monitor_core_tb
// Drives packet and tick items into the loss monitor, keeps a flow table of
// its own, and checks every reported flow field by field in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps
`default_nettype none
module rtp_stream_loss_monitor_core_tb;
    localparam int SLOTS = rslm_pkg::FLOW_SLOTS_DEF;
    localparam int IDLE_LIMIT = 4000;

    typedef struct {
        logic [3:0]         slot;
        logic [31:0]        ip;
        logic [15:0]        port;
        logic [15:0]        first_seq;
        logic [15:0]        last_seq;
        logic [15:0]        seen;
        logic signed [17:0] expected;
        logic signed [17:0] lost;
        logic               last;
    } flow_report_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic cfg_we = 1'b0;
    logic [1:0] cfg_index = '0;
    logic [15:0] cfg_data = '0;
    logic s_valid = 1'b0;
    logic s_ready;
    logic s_command = rslm_pkg::CMD_PACKET;
    logic [31:0] s_dest_ip = '0;
    logic [15:0] s_dest_port = '0;
    logic [7:0] s_first_header_byte = '0;
    logic [15:0] s_seq_number = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    logic [3:0] m_slot;
    logic [31:0] m_stream_ip;
    logic [15:0] m_stream_port;
    logic [15:0] m_first_seq;
    logic [15:0] m_last_seq;
    logic [15:0] m_packets_seen;
    logic signed [17:0] m_packets_expected;
    logic signed [17:0] m_packets_lost;
    logic m_last_report;

    rtp_stream_loss_monitor_core uut (.*);

    always #10 aclk = ~aclk;

    // shadow flow table and registers
    logic [15:0] min_port_r, band_lo_r, band_hi_r;
    logic [7:0]  version_r;
    logic        fl_valid [SLOTS];
    logic [31:0] fl_ip [SLOTS];
    logic [15:0] fl_port [SLOTS];
    logic [15:0] fl_first [SLOTS];
    logic [15:0] fl_last [SLOTS];
    logic [15:0] fl_rcvd [SLOTS];
    logic [15:0] fl_rcvd_rep [SLOTS];
    int          claim_ptr;

    flow_report_t pending_reports[$];
    int errors = 0;
    int idle_cycles = 0;
    int n_items = 0;
    int n_reports = 0;
    int n_ticks = 0;
    bit no_idle = 1'b0;
    int known_ip[$];
    logic [15:0] known_port[$];

    function automatic bit is_rtp(logic [15:0] port, logic [7:0] hdr);
        return (port >= min_port_r || (port >= band_lo_r && port <= band_hi_r))
            && hdr == version_r;
    endfunction

    task automatic track_packet(logic [31:0] ip, logic [15:0] port,
                                logic [7:0] hdr, logic [15:0] seq);
        int i;
        if (!is_rtp(port, hdr)) return;
        for (i = 0; i < SLOTS; i++) begin
            if (fl_valid[i] && fl_ip[i] == ip && fl_port[i] == port) begin
                if (seq == 16'd0) begin
                    fl_first[i] = '0;
                    fl_last[i] = '0;
                    fl_rcvd[i] = 16'd1;
                    fl_rcvd_rep[i] = 16'd1;
                end else begin
                    fl_last[i] = seq;
                    fl_rcvd[i] = fl_rcvd[i] + 16'd1;
                end
                return;
            end
        end
        fl_valid[claim_ptr] = 1'b1;
        fl_ip[claim_ptr] = ip;
        fl_port[claim_ptr] = port;
        fl_first[claim_ptr] = seq;
        fl_last[claim_ptr] = seq;
        fl_rcvd[claim_ptr] = 16'd1;
        claim_ptr = (claim_ptr + 1) % SLOTS;
    endtask

    task automatic walk_tick();
        flow_report_t r;
        logic [17:0] ex;
        int i, n;
        n = 0;
        for (i = 0; i < SLOTS; i++) begin
            if (!fl_valid[i]) continue;
            if (fl_rcvd_rep[i] != fl_rcvd[i]) begin
                ex = {2'b0, fl_last[i]} - {2'b0, fl_first[i]} + 18'd1;
                r.slot = i[3:0];
                r.ip = fl_ip[i];
                r.port = fl_port[i];
                r.first_seq = fl_first[i];
                r.last_seq = fl_last[i];
                r.seen = fl_rcvd[i];
                r.expected = ex;
                r.lost = ex - {2'b0, fl_rcvd[i]};
                r.last = 1'b0;
                pending_reports.push_back(r);
                n++;
            end
            fl_rcvd_rep[i] = fl_rcvd[i];
        end
        if (n > 0) pending_reports[$].last = 1'b1;
    endtask

    task automatic send_item(logic cmd, logic [31:0] ip, logic [15:0] port,
                             logic [7:0] hdr, logic [15:0] seq);
        while (!no_idle && $urandom_range(99) < 34) @(negedge aclk);
        s_valid <= 1'b1;
        s_command <= cmd;
        s_dest_ip <= ip;
        s_dest_port <= port;
        s_first_header_byte <= hdr;
        s_seq_number <= seq;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        if (cmd == rslm_pkg::CMD_TICK) begin
            walk_tick();
            n_ticks++;
        end else begin
            track_packet(ip, port, hdr, seq);
        end
        n_items++;
        @(negedge aclk);
        s_valid <= 1'b0;
        @(negedge aclk);
    endtask

    task automatic send_packet(logic [31:0] ip, logic [15:0] port, logic [15:0] seq);
        send_item(rslm_pkg::CMD_PACKET, ip, port, version_r, seq);
    endtask

    task automatic send_tick();
        send_item(rslm_pkg::CMD_TICK, $urandom, 16'($urandom), 8'($urandom),
                  16'($urandom));
    endtask

    task automatic wait_drained();
        while (pending_reports.size() != 0) @(negedge aclk);
        repeat (SLOTS + 8) @(negedge aclk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [15:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(negedge aclk);
        cfg_we <= 1'b0;
        case (idx)
            rslm_pkg::REG_MIN_PORT:   min_port_r = val;
            rslm_pkg::REG_BAND_FIRST: band_lo_r = val;
            rslm_pkg::REG_BAND_LAST:  band_hi_r = val;
            rslm_pkg::REG_VERSION:    version_r = val[7:0];
        endcase
        @(negedge aclk);
    endtask

    // result checker
    always @(posedge aclk) begin
        flow_report_t e;
        if (aresetn && m_valid && m_ready) begin
            idle_cycles <= 0;
            n_reports++;
            if (pending_reports.size() == 0) begin
                $error("unexpected report for slot %0d", m_slot);
                errors++;
            end else begin
                e = pending_reports.pop_front();
                if (m_slot !== e.slot) begin
                    $error("slot exp %0d got %0d", e.slot, m_slot); errors++;
                end
                if (m_stream_ip !== e.ip) begin
                    $error("stream_ip exp %h got %h", e.ip, m_stream_ip); errors++;
                end
                if (m_stream_port !== e.port) begin
                    $error("stream_port exp %0d got %0d", e.port, m_stream_port);
                    errors++;
                end
                if (m_first_seq !== e.first_seq) begin
                    $error("first_seq exp %0d got %0d", e.first_seq, m_first_seq);
                    errors++;
                end
                if (m_last_seq !== e.last_seq) begin
                    $error("last_seq exp %0d got %0d", e.last_seq, m_last_seq);
                    errors++;
                end
                if (m_packets_seen !== e.seen) begin
                    $error("packets_seen exp %0d got %0d", e.seen, m_packets_seen);
                    errors++;
                end
                if (m_packets_expected !== e.expected) begin
                    $error("packets_expected exp %0d got %0d", e.expected,
                           m_packets_expected);
                    errors++;
                end
                if (m_packets_lost !== e.lost) begin
                    $error("packets_lost exp %0d got %0d", e.lost, m_packets_lost);
                    errors++;
                end
                if (m_last_report !== e.last) begin
                    $error("last_report exp %0d got %0d", e.last, m_last_report);
                    errors++;
                end
            end
        end else if (aresetn && s_valid && s_ready) begin
            idle_cycles <= 0;
        end else if (aresetn) begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("watchdog: no progress, %0d reports outstanding",
                         pending_reports.size());
                $display("*** FAILED ***");
                $finish;
            end
        end
    end

    // receiver stall
    always @(negedge aclk) begin
        m_ready <= no_idle ? 1'b1 : ($urandom_range(99) >= 34);
    end

    task automatic test_port_rule();
        // band edges, min_port edge, version mismatch, extremes of the key
        send_packet(32'h0A000001, 16'd5070, 16'd100);
        send_packet(32'h0A000001, 16'd5074, 16'd200);
        send_packet(32'h0A000001, 16'd5069, 16'd1);
        send_packet(32'h0A000001, 16'd5075, 16'd1);
        send_packet(32'hFFFFFFFF, 16'd9999, 16'd1);
        send_packet(32'hFFFFFFFF, 16'd10000, 16'hFFFF);
        send_packet(32'h00000000, 16'hFFFF, 16'd0);
        send_item(rslm_pkg::CMD_PACKET, 32'h0A000002, 16'd20000, 8'h81, 16'd5);
        send_item(rslm_pkg::CMD_PACKET, 32'h0A000002, 16'd20000, 8'hFF, 16'd5);
        send_tick();
        send_tick();
    endtask

    task automatic test_loss_and_restart();
        send_packet(32'h0A000001, 16'd5070, 16'd105);
        send_packet(32'h0A000001, 16'd5070, 16'd103);
        send_packet(32'hFFFFFFFF, 16'd10000, 16'd0);
        send_packet(32'h00000000, 16'hFFFF, 16'd7);
        send_packet(32'h00000000, 16'hFFFF, 16'd0);
        send_packet(32'h12345678, 16'd30000, 16'd65535);
        send_packet(32'h12345678, 16'd30000, 16'd3);
        send_tick();
    endtask

    task automatic test_eviction();
        int i;
        for (i = 0; i < SLOTS + 4; i++)
            send_packet(32'hC0A80000 + i, 16'd40000, i[15:0] + 16'd1);
        send_tick();
        wait_drained();
    endtask

    task automatic test_config();
        write_reg(rslm_pkg::REG_MIN_PORT, 16'hFFFF);
        write_reg(rslm_pkg::REG_BAND_FIRST, 16'd0);
        write_reg(rslm_pkg::REG_BAND_LAST, 16'd0);
        write_reg(rslm_pkg::REG_VERSION, 16'h00FF);
        send_item(rslm_pkg::CMD_PACKET, 32'h1, 16'd0, 8'hFF, 16'd9);
        send_item(rslm_pkg::CMD_PACKET, 32'h1, 16'hFFFF, 8'hFF, 16'd12);
        send_item(rslm_pkg::CMD_PACKET, 32'h1, 16'd1, 8'hFF, 16'd12);
        send_item(rslm_pkg::CMD_PACKET, 32'h1, 16'd0, 8'h80, 16'd10);
        send_tick();
        wait_drained();
        write_reg(rslm_pkg::REG_MIN_PORT, 16'd0);
        write_reg(rslm_pkg::REG_BAND_FIRST, 16'hFFFF);
        write_reg(rslm_pkg::REG_BAND_LAST, 16'hFFFF);
        write_reg(rslm_pkg::REG_VERSION, 16'h0000);
        send_item(rslm_pkg::CMD_PACKET, 32'h2, 16'd0, 8'h00, 16'd1);
        send_item(rslm_pkg::CMD_PACKET, 32'h2, 16'd0, 8'h00, 16'd4);
        send_tick();
        wait_drained();
        write_reg(rslm_pkg::REG_MIN_PORT, rslm_pkg::MIN_PORT_RST);
        write_reg(rslm_pkg::REG_BAND_FIRST, rslm_pkg::BAND_FIRST_RST);
        write_reg(rslm_pkg::REG_BAND_LAST, rslm_pkg::BAND_LAST_RST);
        write_reg(rslm_pkg::REG_VERSION, {8'h00, rslm_pkg::VERSION_RST});
    endtask

    task automatic test_random(int count);
        int k, j, sel;
        logic [15:0] port;
        logic [31:0] ip;
        logic [15:0] seq;
        for (k = 0; k < 12; k++) begin
            known_ip.push_back($urandom);
            known_port.push_back($urandom_range(1) ? 16'($urandom_range(10000, 65535))
                                                   : 16'($urandom_range(5070, 5074)));
        end
        for (k = 0; k < count; k++) begin
            if (k == count / 3) begin
                // no idling on either side for a while
                no_idle = 1'b1;
            end
            if (k == count / 2) no_idle = 1'b0;
            if (k == 2 * count / 3) wait_drained();
            sel = $urandom_range(99);
            j = $urandom_range(known_ip.size() - 1);
            if (sel < 10) begin
                send_tick();
            end else if (sel < 75) begin
                seq = ($urandom_range(19) == 0) ? 16'd0 : 16'($urandom);
                send_packet(known_ip[j], known_port[j], seq);
            end else if (sel < 85) begin
                ip = $urandom;
                port = 16'($urandom);
                send_packet(ip, port, 16'($urandom));
            end else begin
                send_item(rslm_pkg::CMD_PACKET, known_ip[j], known_port[j], 8'($urandom),
                          16'($urandom));
            end
        end
        send_tick();
    endtask

    initial begin
        min_port_r = rslm_pkg::MIN_PORT_RST;
        band_lo_r = rslm_pkg::BAND_FIRST_RST;
        band_hi_r = rslm_pkg::BAND_LAST_RST;
        version_r = rslm_pkg::VERSION_RST;
        for (int i = 0; i < SLOTS; i++) begin
            fl_valid[i] = 1'b0;
            fl_rcvd_rep[i] = '0;
            fl_rcvd[i] = '0;
        end
        claim_ptr = 0;
        repeat (12) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);
        test_port_rule();
        test_loss_and_restart();
        test_eviction();
        test_config();
        test_random(200);
        wait_drained();
        $display("covered %0d items, %0d ticks, %0d flow reports", n_items, n_ticks,
                 n_reports);
        $display("port rule, version byte, restarts, eviction and register extremes");
        if (errors == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end
endmodule
`default_nettype wire

[sim.f]
rtl/rslm_pkg.sv
rtl/rslm_cell.sv
rtl/rtp_stream_loss_monitor_core.sv
verif/rtp_stream_loss_monitor_core_tb.sv
